// ----- rtl/dabt_pkg.sv -----
// Package for the device address binding table.
// Holds table sizes, field widths, the address mask, command codes, the queue entry type and the response type.
// No dependencies.
package dabt_pkg;

   localparam int TableEntries = 32;
   localparam int AddrBytes    = 7;
   localparam int IdxW         = $clog2(TableEntries);
   localparam int CntW         = 6;
   localparam int DevW         = 22;
   localparam int MsgW         = 11;
   localparam int LenW         = 3;
   localparam int AddrW        = 56;
   localparam int NetW         = 16;
   localparam int CmdW         = 3;
   localparam int SlotW        = 5;

   localparam logic [AddrW-1:0] AddrMask =
      (AddrBytes >= 7) ? {AddrW{1'b1}} : AddrW'((64'd1 << (8 * AddrBytes)) - 64'd1);

   typedef enum logic [CmdW-1:0] {
      CMD_REMOVE   = 3'd0,
      CMD_LOOKUP   = 3'd1,
      CMD_ADD      = 3'd2,
      CMD_BIND_REQ = 3'd3,
      CMD_ADD_BIND = 3'd4,
      CMD_READ_IDX = 3'd5,
      CMD_RSVD_6   = 3'd6,
      CMD_RSVD_7   = 3'd7
   } cmd_type;

   // Classified transaction handed from the front end to the table engine.
   typedef struct packed {
      logic [CmdW-1:0]  cmd;
      logic             idx_ok;
      logic [DevW-1:0]  dev_inst;
      logic [SlotW-1:0] slot_index;
      logic [MsgW-1:0]  max_message;
      logic [LenW-1:0]  link_len;
      logic [AddrW-1:0] link_addr;
      logic [NetW-1:0]  net_number;
      logic [LenW-1:0]  remote_len;
      logic [AddrW-1:0] remote_addr;
   } job_type;

   typedef struct packed {
      logic             found;
      logic [DevW-1:0]  dev_inst;
      logic [MsgW-1:0]  max_message;
      logic [LenW-1:0]  link_len;
      logic [AddrW-1:0] link_addr;
      logic [NetW-1:0]  net_number;
      logic [LenW-1:0]  remote_len;
      logic [AddrW-1:0] remote_addr;
      logic [CntW-1:0]  bound_count;
   } rsp_type;

endpackage

// ----- rtl/dabt_front.sv -----
// Front end: accepts request transactions, classifies them, feeds a two-deep queue.
// Depends on dabt_pkg.
module dabt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [dabt_pkg::CmdW-1:0]  req_cmd,
   input  logic [dabt_pkg::DevW-1:0]  req_dev_inst,
   input  logic [dabt_pkg::SlotW-1:0] req_slot_index,
   input  logic [dabt_pkg::MsgW-1:0]  req_max_message,
   input  logic [dabt_pkg::LenW-1:0]  req_link_len,
   input  logic [dabt_pkg::AddrW-1:0] req_link_addr,
   input  logic [dabt_pkg::NetW-1:0]  req_net_number,
   input  logic [dabt_pkg::LenW-1:0]  req_remote_len,
   input  logic [dabt_pkg::AddrW-1:0] req_remote_addr,
   output logic                       job_valid,
   output dabt_pkg::job_type          job,
   input  logic                       job_take
);
   import dabt_pkg::*;

   job_type    q_ff [2];
   logic       rd_ff, rd_in;
   logic       wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   job_type    cls;
   logic       push;

   // Classify: mask address bytes, flag in-range index
   always_comb begin
      cls             = '0;
      cls.cmd         = req_cmd;
      cls.idx_ok      = (32'(req_slot_index) < TableEntries);
      cls.dev_inst    = req_dev_inst;
      cls.slot_index  = req_slot_index;
      cls.max_message = req_max_message;
      cls.link_len    = req_link_len;
      cls.link_addr   = req_link_addr & AddrMask;
      cls.net_number  = req_net_number;
      cls.remote_len  = req_remote_len;
      cls.remote_addr = req_remote_addr & AddrMask;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ff];

   // Advance queue pointers
   always_comb begin
      rd_in  = rd_ff ^ job_take;
      wr_in  = wr_ff ^ push;
      cnt_in = cnt_ff + 2'(push) - 2'(job_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= cls;
   end

   a_no_take_empty: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid) else $error("take from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> req_stall) else $error("full queue not stalled");

endmodule

// ----- rtl/dabt_engine.sv -----
// Back end: matches a queued transaction against all entries, updates the table,
// and holds the response register. Depends on dabt_pkg.
module dabt_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  dabt_pkg::job_type job,
   output logic              job_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dabt_pkg::rsp_type rsp
);
   import dabt_pkg::*;

   logic [TableEntries-1:0] vld_ff, vld_in;
   logic [TableEntries-1:0] pnd_ff, pnd_in;
   logic [DevW-1:0]  dev_ff  [TableEntries];
   logic [MsgW-1:0]  msg_ff  [TableEntries];
   logic [LenW-1:0]  llen_ff [TableEntries];
   logic [AddrW-1:0] ladr_ff [TableEntries];
   logic [NetW-1:0]  net_ff  [TableEntries];
   logic [LenW-1:0]  rlen_ff [TableEntries];
   logic [AddrW-1:0] radr_ff [TableEntries];

   // Match vectors registered in stage one
   logic [TableEntries-1:0] mv_ff, mp_ff, fv_ff, fp_ff;
   logic [TableEntries-1:0] mv, mp;
   logic                    busy_ff, busy_in;
   job_type                 j_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rv_ff, rv_in;
   logic                    out_free;

   // Stage one: compare all entries in parallel
   always_comb begin
      for (int i = 0; i < TableEntries; i++) begin
         mv[i] = vld_ff[i] && (dev_ff[i] == job.dev_inst);
         mp[i] = pnd_ff[i] && (dev_ff[i] == job.dev_inst);
      end
   end

   assign out_free = !rv_ff || !rsp_stall;
   assign job_take = job_valid && !busy_ff;

   function automatic logic [IdxW:0] first_set(input logic [TableEntries-1:0] v);
      logic [IdxW:0] r;
      r = {1'b1, {IdxW{1'b0}}};
      for (int i = TableEntries - 1; i >= 0; i--)
         if (v[i]) r = {1'b0, IdxW'(i)};
      return r;
   endfunction

   logic [IdxW:0]           hv, hfv, hfp, hfree, hsel;
   logic [TableEntries-1:0] any_m;
   logic [IdxW:0]           hany;
   logic                    do_store, do_new, emit;
   logic [IdxW-1:0]         eidx, widx;
   logic [CntW:0]           cnt;

   // Stage two: act on first hit, build response
   always_comb begin
      hv    = first_set(mv_ff);
      hfv   = first_set(fv_ff);
      hfp   = first_set(fp_ff);
      any_m = mv_ff | mp_ff;
      hany  = first_set(any_m);
      hfree = first_set(~(vld_ff | pnd_ff));
      hsel  = '0;
      vld_in = vld_ff;
      pnd_in = pnd_ff;
      do_store = 1'b0;
      do_new   = 1'b0;
      emit     = 1'b0;
      eidx     = hv[IdxW-1:0];
      widx     = hv[IdxW-1:0];
      unique case (j_ff.cmd) inside
         CMD_REMOVE: begin
            if (!hany[IdxW]) vld_in[hany[IdxW-1:0]] = 1'b0;
         end
         CMD_LOOKUP: emit = !hv[IdxW];
         CMD_ADD, CMD_ADD_BIND: begin
            hsel = (j_ff.cmd == CMD_ADD) ? hfv : hfp;
            if (!hv[IdxW]) begin
               do_store = 1'b1;
            end else if (!hsel[IdxW]) begin
               do_store = 1'b1;
               do_new   = 1'b1;
               widx     = hsel[IdxW-1:0];
               vld_in[hsel[IdxW-1:0]] = 1'b1;
               if (j_ff.cmd == CMD_ADD_BIND) pnd_in[hsel[IdxW-1:0]] = 1'b0;
            end
         end
         CMD_BIND_REQ: begin
            if (!hany[IdxW] && mv_ff[hany[IdxW-1:0]]) begin
               emit = 1'b1;
               eidx = hany[IdxW-1:0];
            end else if (hany[IdxW] && !hfree[IdxW]) begin
               do_new = 1'b1;
               widx   = hfree[IdxW-1:0];
               pnd_in[hfree[IdxW-1:0]] = 1'b1;
            end
         end
         CMD_READ_IDX: begin
            eidx = j_ff.slot_index[IdxW-1:0];
            emit = j_ff.idx_ok && vld_ff[eidx];
         end
         default: ;
      endcase
      cnt = '0;
      for (int i = 0; i < TableEntries; i++) cnt = cnt + (CntW+1)'(vld_in[i]);
      rsp_in = '0;
      if (emit) begin
         rsp_in.found       = 1'b1;
         rsp_in.dev_inst    = dev_ff[eidx];
         rsp_in.max_message = msg_ff[eidx];
         rsp_in.link_len    = llen_ff[eidx];
         rsp_in.link_addr   = ladr_ff[eidx];
         rsp_in.net_number  = net_ff[eidx];
         rsp_in.remote_len  = rlen_ff[eidx];
         rsp_in.remote_addr = radr_ff[eidx];
      end
      rsp_in.bound_count = (cnt > (CntW+1)'(63)) ? CntW'(63) : cnt[CntW-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      rv_in   = rv_ff && rsp_stall;
      if (busy_ff && out_free) begin
         busy_in = 1'b0;
         rv_in   = 1'b1;
      end
      if (job_take) busy_in = 1'b1;
   end

   // Hold state, table flags and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rv_ff   <= 1'b0;
         vld_ff  <= '0;
         pnd_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         rv_ff   <= rv_in;
         if (busy_ff && out_free) begin
            vld_ff <= vld_in;
            pnd_ff <= pnd_in;
         end
      end
      if (job_take) begin
         j_ff  <= job;
         mv_ff <= mv;
         mp_ff <= mp;
         fv_ff <= ~vld_ff;
         fp_ff <= pnd_ff & ~vld_ff;
      end
      if (busy_ff && out_free) begin
         rsp_ff <= rsp_in;
         if (do_new) dev_ff[widx] <= j_ff.dev_inst;
         if (do_store) begin
            msg_ff[widx]  <= j_ff.max_message;
            llen_ff[widx] <= j_ff.link_len;
            ladr_ff[widx] <= j_ff.link_addr;
            net_ff[widx]  <= j_ff.net_number;
            rlen_ff[widx] <= j_ff.remote_len;
            radr_ff[widx] <= j_ff.remote_addr;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp       = rsp_ff;

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |-> !busy_ff) else $error("take while busy");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && out_free) |=> rsp_valid) else $error("result lost");
   a_remove_clears: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && out_free && j_ff.cmd == CMD_REMOVE) |=> $stable(pnd_ff))
      else $error("remove touched pending");

endmodule

// ----- rtl/device_address_binding_table.sv -----
// Top level of the device address binding table.
// Depends on dabt_pkg, dabt_front and dabt_engine.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | cmd, device, slot, address fields
//   rsp_    | out       | rsp_valid/rsp_stall | found, stored fields, bound_count
//
// In the table engine, stage one compares all 32 entries and registers the
// match vectors; stage two picks the first hit, updates the table and loads the
// result once the result register is free; no new transaction enters before that.
// Synchronous active-high reset clears valid and pending flags at once.
// A two-deep queue lets requests arrive while the result register is stalled.
module device_address_binding_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [dabt_pkg::CmdW-1:0]  req_cmd,
   input  logic [dabt_pkg::DevW-1:0]  req_dev_inst,
   input  logic [dabt_pkg::SlotW-1:0] req_slot_index,
   input  logic [dabt_pkg::MsgW-1:0]  req_max_message,
   input  logic [dabt_pkg::LenW-1:0]  req_link_len,
   input  logic [dabt_pkg::AddrW-1:0] req_link_addr,
   input  logic [dabt_pkg::NetW-1:0]  req_net_number,
   input  logic [dabt_pkg::LenW-1:0]  req_remote_len,
   input  logic [dabt_pkg::AddrW-1:0] req_remote_addr,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic [dabt_pkg::DevW-1:0]  rsp_out_dev_inst,
   output logic [dabt_pkg::MsgW-1:0]  rsp_out_max_message,
   output logic [dabt_pkg::LenW-1:0]  rsp_out_link_len,
   output logic [dabt_pkg::AddrW-1:0] rsp_out_link_addr,
   output logic [dabt_pkg::NetW-1:0]  rsp_out_net_number,
   output logic [dabt_pkg::LenW-1:0]  rsp_out_remote_len,
   output logic [dabt_pkg::AddrW-1:0] rsp_out_remote_addr,
   output logic [dabt_pkg::CntW-1:0]  rsp_bound_count
);
   import dabt_pkg::*;

   logic    job_valid, job_take;
   job_type job;
   rsp_type rsp;

   dabt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_dev_inst,
      .req_slot_index, .req_max_message, .req_link_len, .req_link_addr,
      .req_net_number, .req_remote_len, .req_remote_addr,
      .job_valid, .job, .job_take
   );

   dabt_engine u_engine (
      .clock, .reset, .job_valid, .job, .job_take, .rsp_valid, .rsp_stall, .rsp
   );

   // Unpack result fields
   assign rsp_found           = rsp.found;
   assign rsp_out_dev_inst    = rsp.dev_inst;
   assign rsp_out_max_message = rsp.max_message;
   assign rsp_out_link_len    = rsp.link_len;
   assign rsp_out_link_addr   = rsp.link_addr;
   assign rsp_out_net_number  = rsp.net_number;
   assign rsp_out_remote_len  = rsp.remote_len;
   assign rsp_out_remote_addr = rsp.remote_addr;
   assign rsp_bound_count     = rsp.bound_count;

endmodule

// ----- test/device_address_binding_table_test.sv -----
// Self-checking testbench for the device address binding table.
// Depends on dabt_pkg and device_address_binding_table; holds its own table predictor.
`timescale 1ns / 100ps

module device_address_binding_table_test;
   import dabt_pkg::*;

   typedef struct {
      logic [2:0]       cmd;
      logic [DevW-1:0]  dev;
      logic [SlotW-1:0] slot;
      logic [MsgW-1:0]  msg;
      logic [LenW-1:0]  llen;
      logic [AddrW-1:0] laddr;
      logic [NetW-1:0]  net;
      logic [LenW-1:0]  rlen;
      logic [AddrW-1:0] raddr;
   } request_type;

   int error_count = 0;

   // Print one mismatch line and count it.
   task automatic report_error(input string what);
      error_count++;
      $display("ERROR %0t: %s", $realtime, what);
   endtask

   // Binding table predictor and queue of expected responses.
   class binding_scoreboard;
      bit               valid_flag[TableEntries];
      bit               pend_flag[TableEntries];
      logic [DevW-1:0]  dev_tab[TableEntries];
      logic [MsgW-1:0]  msg_tab[TableEntries];
      logic [LenW-1:0]  llen_tab[TableEntries];
      logic [AddrW-1:0] laddr_tab[TableEntries];
      logic [NetW-1:0]  net_tab[TableEntries];
      logic [LenW-1:0]  rlen_tab[TableEntries];
      logic [AddrW-1:0] raddr_tab[TableEntries];
      rsp_type          pending_rsp[$];

      function void store(int i, request_type r);
         msg_tab[i] = r.msg;
         llen_tab[i] = r.llen;
         laddr_tab[i] = r.laddr & AddrMask;
         net_tab[i] = r.net;
         rlen_tab[i] = r.rlen;
         raddr_tab[i] = r.raddr & AddrMask;
      endfunction

      function rsp_type emit(int i);
         rsp_type o;
         o = '0;
         o.found = 1'b1;
         o.dev_inst = dev_tab[i];
         o.max_message = msg_tab[i];
         o.link_len = llen_tab[i];
         o.link_addr = laddr_tab[i];
         o.net_number = net_tab[i];
         o.remote_len = rlen_tab[i];
         o.remote_addr = raddr_tab[i];
         return o;
      endfunction

      function int find_bound(logic [DevW-1:0] d);
         for (int i = 0; i < TableEntries; i++)
            if (valid_flag[i] && dev_tab[i] == d) return i;
         return -1;
      endfunction

      // Apply one accepted transaction and queue the response it yields.
      function void note_request(request_type r);
         rsp_type o;
         int hit;
         int cnt;
         bit done;
         o = '0;
         case (r.cmd) inside
            CMD_REMOVE: begin
               for (int i = 0; i < TableEntries; i++)
                  if ((valid_flag[i] || pend_flag[i]) && dev_tab[i] == r.dev) begin
                     valid_flag[i] = 0;
                     break;
                  end
            end
            CMD_LOOKUP: begin
               hit = find_bound(r.dev);
               if (hit >= 0) o = emit(hit);
            end
            CMD_ADD, CMD_ADD_BIND: begin
               hit = find_bound(r.dev);
               if (hit >= 0) store(hit, r);
               else
                  for (int i = 0; i < TableEntries; i++)
                     if (!valid_flag[i] && (r.cmd == CMD_ADD || pend_flag[i])) begin
                        valid_flag[i] = 1;
                        if (r.cmd == CMD_ADD_BIND) pend_flag[i] = 0;
                        dev_tab[i] = r.dev;
                        store(i, r);
                        break;
                     end
            end
            CMD_BIND_REQ: begin
               done = 0;
               for (int i = 0; i < TableEntries && !done; i++) begin
                  if (valid_flag[i] && dev_tab[i] == r.dev) begin
                     o = emit(i);
                     done = 1;
                  end else if (pend_flag[i] && dev_tab[i] == r.dev) done = 1;
               end
               if (!done)
                  for (int i = 0; i < TableEntries; i++)
                     if (!valid_flag[i] && !pend_flag[i]) begin
                        pend_flag[i] = 1;
                        dev_tab[i] = r.dev;
                        break;
                     end
            end
            CMD_READ_IDX: if (valid_flag[r.slot]) o = emit(r.slot);
            default: ;
         endcase
         cnt = 0;
         foreach (valid_flag[i]) cnt += valid_flag[i];
         o.bound_count = CntW'(cnt);
         pending_rsp.push_back(o);
      endfunction

      // Compare one response with the oldest expectation.
      task check_response(rsp_type got);
         rsp_type w;
         if (pending_rsp.size() == 0) begin
            report_error("response with nothing expected");
            return;
         end
         w = pending_rsp.pop_front();
         if (got.found !== w.found) report_error($sformatf("found %0b exp %0b", got.found, w.found));
         if (got.dev_inst !== w.dev_inst)
            report_error($sformatf("device %0h exp %0h", got.dev_inst, w.dev_inst));
         if (got.max_message !== w.max_message)
            report_error($sformatf("max_message %0h exp %0h", got.max_message, w.max_message));
         if (got.link_len !== w.link_len)
            report_error($sformatf("link_len %0h exp %0h", got.link_len, w.link_len));
         if (got.link_addr !== w.link_addr)
            report_error($sformatf("link_addr %0h exp %0h", got.link_addr, w.link_addr));
         if (got.net_number !== w.net_number)
            report_error($sformatf("net %0h exp %0h", got.net_number, w.net_number));
         if (got.remote_len !== w.remote_len)
            report_error($sformatf("remote_len %0h exp %0h", got.remote_len, w.remote_len));
         if (got.remote_addr !== w.remote_addr)
            report_error($sformatf("remote_addr %0h exp %0h", got.remote_addr, w.remote_addr));
         if (got.bound_count !== w.bound_count)
            report_error($sformatf("count %0d exp %0d", got.bound_count, w.bound_count));
      endtask
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   logic [CmdW-1:0]  req_cmd = '0;
   logic [DevW-1:0]  req_dev_inst = '0;
   logic [SlotW-1:0] req_slot_index = '0;
   logic [MsgW-1:0]  req_max_message = '0;
   logic [LenW-1:0]  req_link_len = '0;
   logic [AddrW-1:0] req_link_addr = '0;
   logic [NetW-1:0]  req_net_number = '0;
   logic [LenW-1:0]  req_remote_len = '0;
   logic [AddrW-1:0] req_remote_addr = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1;
   logic             rsp_found;
   logic [DevW-1:0]  rsp_out_dev_inst;
   logic [MsgW-1:0]  rsp_out_max_message;
   logic [LenW-1:0]  rsp_out_link_len;
   logic [AddrW-1:0] rsp_out_link_addr;
   logic [NetW-1:0]  rsp_out_net_number;
   logic [LenW-1:0]  rsp_out_remote_len;
   logic [AddrW-1:0] rsp_out_remote_addr;
   logic [CntW-1:0]  rsp_bound_count;

   binding_scoreboard table_model = new();
   bit  stimulus_done = 0;
   bit  long_hold = 0;
   logic [DevW-1:0] dev_pool[8];

   device_address_binding_table i_dut (.*);

   initial forever #4 clock = ~clock;

   // Drive one transaction at the falling edge and hold it until accepted.
   task automatic send_request(request_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_dev_inst <= r.dev;
      req_slot_index <= r.slot;
      req_max_message <= r.msg;
      req_link_len <= r.llen;
      req_link_addr <= r.laddr;
      req_net_number <= r.net;
      req_remote_len <= r.rlen;
      req_remote_addr <= r.raddr;
      do @(posedge clock); while (req_stall);
      table_model.note_request(r);
   endtask

   task automatic go_idle(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic request_type random_request(bit legal);
      request_type r;
      r.cmd = legal ? 3'($urandom_range(0, 5)) : 3'($urandom_range(0, 7));
      r.dev = ($urandom_range(0, 9) == 0) ? DevW'($urandom) : dev_pool[$urandom_range(0, 7)];
      r.slot = SlotW'($urandom);
      r.msg = MsgW'($urandom_range(0, 2047));
      r.llen = LenW'($urandom);
      r.laddr = AddrW'({$urandom, $urandom});
      r.net = NetW'($urandom);
      r.rlen = LenW'($urandom);
      r.raddr = AddrW'({$urandom, $urandom});
      return r;
   endfunction

   function automatic request_type make_req(logic [2:0] c, logic [DevW-1:0] d, bit ones);
      request_type r;
      r = random_request(1);
      r.cmd = c;
      r.dev = d;
      r.msg = ones ? '1 : '0;
      r.llen = ones ? '1 : '0;
      r.laddr = ones ? '1 : '0;
      r.net = ones ? '1 : '0;
      r.rlen = ones ? '1 : '0;
      r.raddr = ones ? '1 : '0;
      return r;
   endfunction

   // Stimulus: directed corners, then bursts of random commands.
   initial begin
      request_type r;
      foreach (dev_pool[i]) dev_pool[i] = DevW'($urandom);
      dev_pool[0] = '0;
      dev_pool[1] = '1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_request(make_req(CMD_LOOKUP, '0, 0));
      send_request(make_req(CMD_ADD, '0, 0));
      send_request(make_req(CMD_ADD, '1, 1));
      send_request(make_req(CMD_LOOKUP, '1, 0));
      send_request(make_req(CMD_ADD, '1, 0));
      send_request(make_req(CMD_BIND_REQ, '0, 0));
      send_request(make_req(CMD_BIND_REQ, 22'h155555, 0));
      send_request(make_req(CMD_BIND_REQ, 22'h155555, 0));
      send_request(make_req(CMD_ADD_BIND, 22'h2AAAAA, 1));
      send_request(make_req(CMD_ADD_BIND, 22'h123, 1));
      send_request(make_req(CMD_REMOVE, '1, 0));
      send_request(make_req(CMD_REMOVE, 22'h777, 0));
      r = make_req(CMD_READ_IDX, '0, 0);
      r.slot = '1;
      send_request(r);
      r.slot = '0;
      send_request(r);
      send_request(make_req(CMD_RSVD_6, '0, 1));
      send_request(make_req(CMD_RSVD_7, '1, 1));
      // Fill the table to overflow, then read it back.
      for (int i = 0; i < TableEntries + 2; i++)
         send_request(make_req(CMD_ADD, DevW'(i + 100), i[0]));
      for (int i = 0; i < TableEntries; i++) begin
         r = make_req(CMD_READ_IDX, '0, 0);
         r.slot = SlotW'(i);
         send_request(r);
      end
      send_request(make_req(CMD_BIND_REQ, 22'h999, 0));
      for (int i = 0; i < TableEntries; i++)
         send_request(make_req(CMD_REMOVE, DevW'(i + 100), 0));
      // Random part: mostly well-formed commands on a small device pool.
      long_hold = 1;
      for (int n = 0; n < 640; ) begin
         int burst;
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst; k++, n++)
            send_request(random_request($urandom_range(0, 15) != 0));
         if ($urandom_range(0, 2) != 0) go_idle($urandom_range(0, 6));
      end
      go_idle(0);
      stimulus_done = 1;
   end

   // Response side: stall pattern with one long hold-off.
   initial begin
      int hold_cycles;
      hold_cycles = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (long_hold && hold_cycles < 60) begin
            hold_cycles++;
            rsp_stall <= 1'b1;
         end else if ((($time / 2000) % 3) == 0) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // Sample accepted responses at the rising edge.
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.found = rsp_found;
         got.dev_inst = rsp_out_dev_inst;
         got.max_message = rsp_out_max_message;
         got.link_len = rsp_out_link_len;
         got.link_addr = rsp_out_link_addr;
         got.net_number = rsp_out_net_number;
         got.remote_len = rsp_out_remote_len;
         got.remote_addr = rsp_out_remote_addr;
         got.bound_count = rsp_bound_count;
         table_model.check_response(got);
      end
   end

   // Drain, then give the verdict.
   initial begin
      wait (stimulus_done);
      while (table_model.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && table_model.pending_rsp.size() == 0)
         $display("** device_address_binding_table: PASSED **");
      else
         $display("** device_address_binding_table: FAILED **");
      $finish;
   end

   initial begin
      #2ms;
      $display("** device_address_binding_table: FAILED **");
      $finish;
   end

endmodule
